@@ src/rds_pkg.sv @@
// Package for the radix digit string converter: types, constants and the
// ASCII glyph function. No dependencies.
`default_nettype none

package rds_pkg;

  // Width of the input word as it stands on the port.
  localparam int unsigned VALUE_BITS = 64;
  // Width of one digit and of the ASCII character.
  localparam int unsigned DIGIT_BITS = 4;
  localparam int unsigned CHAR_BITS  = 7;
  // Width of the radix register and its limits.
  localparam int unsigned RADIX_BITS = 5;
  localparam logic [RADIX_BITS-1:0] RADIX_MIN   = 5'd2;
  localparam logic [RADIX_BITS-1:0] RADIX_MAX   = 5'd16;
  localparam logic [RADIX_BITS-1:0] RADIX_RESET = 5'd10;
  // ASCII bases: '0' for digits below ten, 'A' minus ten above.
  localparam logic [CHAR_BITS-1:0] ASCII_ZERO   = 7'd48;
  localparam logic [CHAR_BITS-1:0] ASCII_LETTER = 7'd55;

  typedef logic [DIGIT_BITS-1:0] digit_t;
  typedef logic [RADIX_BITS-1:0] radix_t;
  typedef logic [CHAR_BITS-1:0]  char_t;

  // Control word from the sequencer to the digit row.
  typedef struct packed {
    logic clr;     // zero every cell before a conversion
    logic dbl;     // double the row and add bit_in
    logic shift;   // move every cell one place up for readout
    logic bit_in;  // next value bit, most significant first
  } rds_row_ctl_t;

  // Map a digit to its ASCII character.
  function automatic char_t digit_glyph(input digit_t d);
    char_t ext;
    ext = {3'b000, d};
    if (d < 4'd10) begin
      digit_glyph = ASCII_ZERO + ext;
    end else begin
      digit_glyph = ASCII_LETTER + ext;
    end
  endfunction

endpackage

`default_nettype wire

@@ src/radix_digit_string.sv @@
// Top level of the radix digit string converter: radix register, sequencer
// and value shift register. Uses rds_pkg, rds_digit_row and rds_out_reg.
`default_nettype none

// Channel   Direction  Word                          Handshake
// in        sink       in_value (64 b)               in_valid / in_ready
// out       source     out_digit_char, last_digit    out_valid / out_ready
// cfg       sink       cfg_wr_data (radix, 5 b)      cfg_wr_en, no wait
//
// An item is loaded, converted in the digit row by bit-serial doubling, one
// value bit at a time, and read out one digit cell at a time.
// Leading zero cells are dropped during readout without producing a word.
// A stalled sink holds the readout; the next value is taken as soon as the
// last digit sits in the output register. Reset is synchronous, active low.

module radix_digit_string #(
  parameter int unsigned VALUE_WIDTH = 64
) (
  input  wire                        clk,
  input  wire                        rst_n,
  input  wire                        in_valid,
  output logic                       in_ready,
  input  wire [rds_pkg::VALUE_BITS-1:0] in_value,
  output logic                       out_valid,
  input  wire                        out_ready,
  output rds_pkg::char_t             out_digit_char,
  output logic                       out_last_digit,
  input  wire                        cfg_wr_en,
  input  wire [rds_pkg::RADIX_BITS-1:0] cfg_wr_data
);
  import rds_pkg::*;

  localparam int unsigned CW = $clog2(VALUE_WIDTH + 1);

  typedef enum logic [1:0] {ST_IDLE, ST_CONV, ST_EMIT} state_t;

  state_t                  state_r;
  logic [CW-1:0]           cnt_r;
  logic                    seen_r;
  logic [VALUE_WIDTH-1:0]  val_r;
  radix_t                  radix_r;
  radix_t                  eff_radix;
  rds_row_ctl_t            row_ctl;
  digit_t                  top_digit;
  logic                    out_free;
  logic                    load;
  logic                    last;
  logic                    step;
  logic                    skip;

  // Radix register, saturated to the supported range on use.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radix_r <= RADIX_RESET;
    end else if (cfg_wr_en) begin
      radix_r <= cfg_wr_data;
    end
  end

  always_comb begin
    if (radix_r < RADIX_MIN) begin
      eff_radix = RADIX_MIN;
    end else if (radix_r > RADIX_MAX) begin
      eff_radix = RADIX_MAX;
    end else begin
      eff_radix = radix_r;
    end
  end

  assign in_ready = (state_r == ST_IDLE);

  // Readout decisions: skip leading zero cells, but always emit the last.
  assign step = (state_r == ST_EMIT) && out_free;
  assign skip = !seen_r && (top_digit == '0) && (cnt_r != CW'(1));
  assign load = step && !skip;
  assign last = (cnt_r == CW'(1));

  // Row control.
  always_comb begin
    row_ctl.clr    = in_valid && in_ready;
    row_ctl.dbl    = (state_r == ST_CONV);
    row_ctl.shift  = step;
    row_ctl.bit_in = val_r[VALUE_WIDTH-1];
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
      seen_r  <= 1'b0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            state_r <= ST_CONV;
            cnt_r   <= CW'(VALUE_WIDTH);
          end
        end
        ST_CONV: begin
          if (cnt_r == CW'(1)) begin
            state_r <= ST_EMIT;
            cnt_r   <= CW'(VALUE_WIDTH);
            seen_r  <= 1'b0;
          end else begin
            cnt_r <= cnt_r - CW'(1);
          end
        end
        ST_EMIT: begin
          if (step) begin
            cnt_r <= cnt_r - CW'(1);
            if (!skip) begin
              seen_r <= 1'b1;
            end
            if (last) begin
              state_r <= ST_IDLE;
            end
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  // Value shift register, most significant bit leaves first.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      val_r <= in_value[VALUE_WIDTH-1:0];
    end else if (state_r == ST_CONV) begin
      val_r <= {val_r[VALUE_WIDTH-2:0], 1'b0};
    end
  end

  rds_digit_row #(
    .CELLS (VALUE_WIDTH)
  ) u_row (
    .clk       (clk),
    .ctl       (row_ctl),
    .radix     (eff_radix),
    .top_digit (top_digit)
  );

  rds_out_reg u_out (
    .clk            (clk),
    .rst_n          (rst_n),
    .load           (load),
    .digit          (top_digit),
    .last           (last),
    .free           (out_free),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_digit_char (out_digit_char),
    .out_last_digit (out_last_digit)
  );

  // A taken value starts a full-length conversion.
  a_start_conv: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == ST_CONV) && (cnt_r == CW'(VALUE_WIDTH)))
    else $error("conversion did not start after a value was taken");

  // Conversion hands over to readout with a full cell count.
  a_conv_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CONV && cnt_r == CW'(1)) |=>
      (state_r == ST_EMIT) && (cnt_r == CW'(VALUE_WIDTH)))
    else $error("readout did not follow the conversion");

  // Every digit read out lies below the radix.
  a_digit_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT) |-> ({1'b0, top_digit} < eff_radix))
    else $error("digit out of range for the radix");

  // The final word returns the block to idle.
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (load && last) |=> (state_r == ST_IDLE) && out_valid && out_last_digit)
    else $error("final digit did not end the run");

  // The counter never runs dry while busy.
  a_cnt_live: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> (cnt_r != '0))
    else $error("cycle counter empty while busy");

endmodule

`default_nettype wire

@@ src/rds_digit_row.sv @@
// Row of radix digit cells: converts the value bit-serially by doubling in
// the chosen radix, then shifts the digits out from the top. Uses rds_pkg.
`default_nettype none

module rds_digit_row #(
  parameter int unsigned CELLS = 64
) (
  input  wire                   clk,
  input  rds_pkg::rds_row_ctl_t ctl,
  input  rds_pkg::radix_t       radix,
  output rds_pkg::digit_t       top_digit
);
  import rds_pkg::*;

  digit_t            cell_r   [CELLS];
  digit_t            cell_nxt [CELLS];
  logic [CELLS-1:0]  gen;
  logic [CELLS-1:0]  prop;
  logic [CELLS:0]    csum;
  logic [CELLS-1:0]  cin;

  // Per cell: a carry leaves when 2d+c reaches the radix. It always does for
  // 2d >= radix and depends on the incoming carry only when 2d+1 == radix.
  always_comb begin
    for (int i = 0; i < CELLS; i++) begin
      gen[i]  = ({cell_r[i], 1'b0} >= radix);
      prop[i] = ({cell_r[i], 1'b1} == radix);
    end
  end

  // The carry chain is resolved by one wide add of generate and propagate.
  assign csum = {1'b0, gen | prop} + {1'b0, gen} + {{CELLS{1'b0}}, ctl.bit_in};
  assign cin  = csum[CELLS-1:0] ^ (gen | prop) ^ gen;

  // New digit of each cell after doubling.
  always_comb begin
    logic       co;
    radix_t     twice;
    radix_t     sub;
    for (int i = 0; i < CELLS; i++) begin
      co          = gen[i] | (prop[i] & cin[i]);
      twice       = {cell_r[i], cin[i]};
      sub         = co ? radix : '0;
      twice       = twice - sub;
      cell_nxt[i] = twice[DIGIT_BITS-1:0];
    end
  end

  // Cell storage: clear, double or shift up toward the top cell.
  always_ff @(posedge clk) begin
    if (ctl.clr) begin
      for (int i = 0; i < CELLS; i++) cell_r[i] <= '0;
    end else if (ctl.dbl) begin
      for (int i = 0; i < CELLS; i++) cell_r[i] <= cell_nxt[i];
    end else if (ctl.shift) begin
      cell_r[0] <= '0;
      for (int i = 1; i < CELLS; i++) cell_r[i] <= cell_r[i-1];
    end
  end

  assign top_digit = cell_r[CELLS-1];

endmodule

`default_nettype wire

@@ src/rds_out_reg.sv @@
// Output register of the converter: turns a digit into its ASCII word and
// holds it until the sink takes it. Uses rds_pkg.
`default_nettype none

module rds_out_reg (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               load,
  input  rds_pkg::digit_t   digit,
  input  wire               last,
  output logic              free,
  output logic              out_valid,
  input  wire               out_ready,
  output rds_pkg::char_t    out_digit_char,
  output logic              out_last_digit
);
  import rds_pkg::*;

  logic   valid_r;
  logic   valid_nxt;
  char_t  char_r;
  logic   last_r;

  // Register is free when empty or being emptied this cycle.
  assign free = !valid_r || out_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk) begin
    if (load) begin
      char_r <= digit_glyph(digit);
      last_r <= last;
    end
  end

  assign out_valid      = valid_r;
  assign out_digit_char = char_r;
  assign out_last_digit = last_r;

endmodule

`default_nettype wire

@@ tb/sv/tb.sv @@
// Self-checking testbench for radix_digit_string: drives values and radix settings,
// predicts the ASCII digit words and compares every word the block returns.
// Depends on rds_pkg and the radix_digit_string RTL only.

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rds_pkg::*;

  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned PHASE_ITEMS = 16;
  localparam int unsigned RAND_PHASES = 12;
  localparam int unsigned MAX_REPORTS = 10;

  // One expected output word: the character and the final-digit flag.
  typedef struct packed {
    char_t ch;
    logic  last;
  } digit_word_t;

  // Holds the radix copy, turns each accepted value into its digit words and
  // checks returned words against them in order.
  class digit_scoreboard;
    radix_t        radix_reg;
    digit_word_t   expected_words[$];
    int unsigned   mismatches;
    logic [6:0]    digit_count;
    string         glyph_set;

    function new();
      radix_reg   = RADIX_RESET;
      mismatches  = 0;
      digit_count = '0;
      glyph_set   = "0123456789ABCDEF";
    endfunction

    function void set_radix(radix_t r);
      radix_reg = r;
    endfunction

    // Out-of-range radix settings saturate to the nearest legal base.
    function int unsigned base();
      if (radix_reg < RADIX_MIN) return RADIX_MIN;
      if (radix_reg > RADIX_MAX) return RADIX_MAX;
      return radix_reg;
    endfunction

    // Divide repeatedly, least significant digit first, then queue the
    // characters most significant first with the flag on the final one.
    function void note_value(logic [VALUE_BITS-1:0] v);
      logic [3:0]           digits [64];
      logic [VALUE_BITS-1:0] rest;
      int unsigned          b;
      int unsigned          n;
      digit_word_t          w;
      b    = base();
      rest = v;
      n    = 0;
      do begin
        digits[n] = 4'(rest % b);
        rest      = rest / b;
        n++;
      end while (rest != 0 && n < VALUE_BITS);
      digit_count = 7'(n);
      for (int k = int'(n) - 1; k >= 0; k--) begin
        w.ch   = char_t'(glyph_set[digits[k]]);
        w.last = (k == 0);
        expected_words.push_back(w);
      end
    endfunction

    // Compare one returned word with the oldest expected word.
    function void check_digit(char_t ch, logic last);
      digit_word_t w;
      if (expected_words.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected digit word: char %0d last %0d", ch, last);
        return;
      end
      w = expected_words.pop_front();
      if (ch !== w.ch || last !== w.last) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("digit word mismatch: expected char %0d last %0d, got char %0d last %0d",
                   w.ch, w.last, ch, last);
      end
    endfunction

    function int unsigned pending();
      return expected_words.size();
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   in_valid;
  logic                   in_ready;
  logic [VALUE_BITS-1:0]  in_value;
  logic                   out_valid;
  logic                   out_ready;
  char_t                  out_digit_char;
  logic                   out_last_digit;
  logic                   cfg_wr_en;
  radix_t                 cfg_wr_data;

  digit_scoreboard        sb;
  logic [VALUE_BITS-1:0]  directed_values[$];
  bit                     in_idle_on;
  bit                     out_idle_on;
  int unsigned            stall_cycles;

  radix_digit_string uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_value       (in_value),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_digit_char (out_digit_char),
    .out_last_digit (out_last_digit),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data)
  );

  always #5 clk = ~clk;

  // Idle lengths: mostly none or short, now and then a long one.
  function automatic int unsigned pick_gap(bit enabled);
    int unsigned r;
    if (!enabled) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Random values: full width, random bit length, small, values at powers of
  // the current base where the digit count steps up, and the extreme values.
  function automatic logic [VALUE_BITS-1:0] rand_value(int unsigned b);
    int unsigned           kind;
    int unsigned           steps;
    logic [VALUE_BITS-1:0] p;
    kind = $urandom_range(0, 9);
    case (kind)
      0, 1, 2, 3: return {$urandom, $urandom};
      4, 5:       return {$urandom, $urandom} >> $urandom_range(0, 63);
      6:          return VALUE_BITS'($urandom_range(0, 300));
      7, 8: begin
        p     = 1;
        steps = $urandom_range(1, 64);
        for (int k = 0; k < steps && p <= ({VALUE_BITS{1'b1}} / b); k++) p = p * b;
        return (kind == 7) ? p : p - 1;
      end
      default: begin
        case ($urandom_range(0, 2))
          0:       return {VALUE_BITS{1'b1}};
          1:       return '0;
          default: return {1'b1, {(VALUE_BITS-1){1'b0}}};
        endcase
      end
    endcase
  endfunction

  // Present one value and hold it until the block takes the word.
  task automatic send_value(input logic [VALUE_BITS-1:0] v);
    int unsigned gap;
    gap = pick_gap(in_idle_on);
    if (gap > 0) begin
      @(negedge clk) in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_value <= v;
    do @(posedge clk); while (!in_ready);
    sb.note_value(v);
  endtask

  // Radix writes happen only while nothing is in flight.
  task automatic write_radix(input radix_t r);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= r;
    @(posedge clk);
    sb.set_radix(r);
    @(negedge clk) cfg_wr_en <= 1'b0;
  endtask

  // One setting: optional radix write, queued directed values, then random
  // ones; returns once every expected digit word has come back.
  task automatic run_phase(input radix_t r, input bit do_write, input int unsigned n_random);
    if (do_write) write_radix(r);
    while (directed_values.size() != 0) send_value(directed_values.pop_front());
    repeat (n_random) send_value(rand_value(sb.base()));
    @(negedge clk) in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // Result side: stall at random, take each word and check it.
  task automatic collect_digits();
    int unsigned gap;
    forever begin
      gap = pick_gap(out_idle_on);
      if (gap > 0) begin
        @(negedge clk) out_ready <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      @(negedge clk) out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      sb.check_digit(out_digit_char, out_last_digit);
    end
  endtask

  // Watchdog: end the run when no word moves on either channel for too long.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        stall_cycles <= 0;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
      if (stall_cycles >= STALL_LIMIT) begin
        $display("[radix_digit_string] ERROR");
        $finish;
      end
    end
  end

  // Main sequence: reset, directed settings, random settings, final verdict.
  initial begin
    radix_t r;
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_value     = '0;
    out_ready    = 1'b0;
    cfg_wr_en    = 1'b0;
    cfg_wr_data  = '0;
    stall_cycles = 0;
    in_idle_on   = 1'b1;
    out_idle_on  = 1'b1;
    sb           = new();
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    fork
      collect_digits();
    join_none

    // Reset radix of ten: single digits, digit-count steps and full width.
    directed_values = '{64'd0, 64'd1, 64'd9, 64'd10, 64'd99, 64'd100,
                        64'hFFFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000,
                        64'd9999999999999999999, 64'd10000000000000000000};
    run_phase(RADIX_RESET, 1'b0, 0);
    // Base two gives the longest digit strings.
    directed_values = '{64'hFFFF_FFFF_FFFF_FFFF, 64'd0, 64'd1, 64'h8000_0000_0000_0000};
    run_phase(5'd2, 1'b1, 0);
    directed_values = '{64'hFFFF_FFFF_FFFF_FFFF, 64'd0, 64'hF, 64'h10,
                        64'h0123_4567_89AB_CDEF};
    run_phase(5'd16, 1'b1, 0);
    // Radix settings below two and above sixteen saturate.
    directed_values = '{64'd5, 64'hFFFF_FFFF_FFFF_FFFF};
    run_phase(5'd0, 1'b1, 0);
    directed_values = '{64'd6};
    run_phase(5'd1, 1'b1, 0);
    directed_values = '{64'd255};
    run_phase(5'd17, 1'b1, 0);
    directed_values = '{64'hFFFF_FFFF_FFFF_FFFF};
    run_phase(5'd31, 1'b1, 0);

    // Random settings, some of them with one side never idling.
    for (int p = 0; p < RAND_PHASES; p++) begin
      if ($urandom_range(0, 9) == 0) begin
        r = radix_t'($urandom_range(0, 31));
      end else begin
        r = radix_t'($urandom_range(2, 16));
      end
      in_idle_on  = ($urandom_range(0, 3) != 0);
      out_idle_on = ($urandom_range(0, 3) != 0);
      run_phase(r, 1'b1, PHASE_ITEMS);
    end

    repeat (20) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("[radix_digit_string] OK");
    end else begin
      $display("[radix_digit_string] ERROR");
    end
    $finish;
  end

endmodule
